@@ design/mcq_pkg.sv @@
// Shared constants, types and control codes of the min-conflicts queen step unit.
package mcq_pkg;

  localparam int MAX_QUEENS_DEF = 64;
  localparam logic [6:0] BOARD_SIZE_RST = 7'd8;
  localparam int TOTAL_MAX = 8191;
  localparam int LOAD_BIAS = 3;
  localparam int RAND_W = 16;

  typedef enum logic [1:0] {
    LINE_HOLD,
    LINE_INC,
    LINE_DEC
  } line_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CSCAN,
    S_CMOD,
    S_RSCAN,
    S_RMOD,
    S_PRDQ,
    S_PRDL,
    S_PRMV,
    S_PARD,
    S_PADD,
    S_REPORT
  } state_t;

endpackage

@@ design/mcq_lines.sv @@
// Row and diagonal queen-count memories with read-modify-write and a clear sweep.
module mcq_lines #(
  parameter int MAX_QUEENS = mcq_pkg::MAX_QUEENS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  output logic                                   clearing,
  input  logic [$clog2(MAX_QUEENS)-1:0]          rd_col,
  input  logic [$clog2(MAX_QUEENS)-1:0]          rd_row,
  output logic [$clog2(3*MAX_QUEENS+1)-1:0]      rd_sum,
  input  mcq_pkg::line_op_t                      op
);
  import mcq_pkg::*;

  localparam int QW = $clog2(MAX_QUEENS);
  localparam int CW = $clog2(MAX_QUEENS + 1);
  localparam int DD = 2 * MAX_QUEENS - 1;
  localparam int DW = $clog2(DD);
  localparam int SW = $clog2(3 * MAX_QUEENS + 1);

  logic [CW-1:0] row_mem  [MAX_QUEENS];
  logic [CW-1:0] fall_mem [DD];
  logic [CW-1:0] rise_mem [DD];

  logic [CW-1:0] row_q, fall_q, rise_q;
  logic [QW-1:0] row_a;
  logic [DW-1:0] fall_a, rise_a;
  logic [DW-1:0] clr_idx;

  logic [DW-1:0] fidx, ridx;
  logic          row_we, diag_we;
  logic [QW-1:0] row_wa;
  logic [DW-1:0] fall_wa, rise_wa;
  logic [CW-1:0] row_wd, fall_wd, rise_wd;

  assign fidx = DW'(rd_col) + DW'(MAX_QUEENS - 1) - DW'(rd_row);
  assign ridx = DW'(rd_col) + DW'(rd_row);

  always_comb begin
    if (clearing) begin
      row_we  = (32'(clr_idx) < MAX_QUEENS);
      diag_we = 1'b1;
      row_wa  = clr_idx[QW-1:0];
      fall_wa = clr_idx;
      rise_wa = clr_idx;
      row_wd  = '0;
      fall_wd = '0;
      rise_wd = '0;
    end else begin
      row_we  = (op != LINE_HOLD);
      diag_we = (op != LINE_HOLD);
      row_wa  = row_a;
      fall_wa = fall_a;
      rise_wa = rise_a;
      if (op == LINE_INC) begin
        row_wd  = row_q + CW'(1);
        fall_wd = fall_q + CW'(1);
        rise_wd = rise_q + CW'(1);
      end else begin
        row_wd  = row_q - CW'(1);
        fall_wd = fall_q - CW'(1);
        rise_wd = rise_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (diag_we) begin
      fall_mem[fall_wa] <= fall_wd;
      rise_mem[rise_wa] <= rise_wd;
    end
    row_q  <= row_mem[rd_row];
    fall_q <= fall_mem[fidx];
    rise_q <= rise_mem[ridx];
    row_a  <= rd_row;
    fall_a <= fidx;
    rise_a <= ridx;
  end

  // Sweep all row and diagonal entries once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == DW'(DD - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + DW'(1);
    end
  end

  assign rd_sum = SW'(row_q) + SW'(fall_q) + SW'(rise_q);

endmodule

@@ design/mcq_board.sv @@
// Queen row memory and placed flags, one entry per column.
module mcq_board #(
  parameter int MAX_QUEENS = mcq_pkg::MAX_QUEENS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(MAX_QUEENS)-1:0] rd_col,
  output logic [$clog2(MAX_QUEENS)-1:0] rd_row,
  output logic                          rd_placed,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_QUEENS)-1:0] wr_col,
  input  logic [$clog2(MAX_QUEENS)-1:0] wr_row
);
  import mcq_pkg::*;

  localparam int QW = $clog2(MAX_QUEENS);

  logic [QW-1:0]         qrow_mem [MAX_QUEENS];
  logic [MAX_QUEENS-1:0] placed;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      qrow_mem[wr_col] <= wr_row;
    end
    rd_row <= qrow_mem[rd_col];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      placed    <= '0;
      rd_placed <= 1'b0;
    end else begin
      if (wr_en) begin
        placed[wr_col] <= 1'b1;
      end
      rd_placed <= placed[rd_col];
    end
  end

endmodule

@@ design/mcq_mod.sv @@
// Bit-serial remainder of a random word by a tie count, one bit per cycle.
module mcq_mod #(
  parameter int MAX_QUEENS = mcq_pkg::MAX_QUEENS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [mcq_pkg::RAND_W-1:0]      dividend,
  input  logic [$clog2(MAX_QUEENS+1)-1:0] divisor,
  output logic                            done,
  output logic [$clog2(MAX_QUEENS+1)-1:0] rem
);
  import mcq_pkg::*;

  localparam int NW = $clog2(MAX_QUEENS + 1);
  localparam int KW = $clog2(RAND_W);

  logic          busy;
  logic [KW-1:0] cnt;
  logic [RAND_W-1:0] dvd;
  logic [NW-1:0] dsr;
  logic [NW:0]   rem_sh;
  logic [NW-1:0] rem_next;

  assign rem_sh   = {rem, dvd[RAND_W-1]};
  assign rem_next = (rem_sh >= {1'b0, dsr}) ? NW'(rem_sh - {1'b0, dsr}) : NW'(rem_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + KW'(1);
        if (cnt == KW'(RAND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 1;
    end
  end

endmodule

@@ design/min_conflicts_queen_solver_step_unit.sv @@
// Min-conflicts N-queens step unit: board memories, scan sequencer and result port.
// Place: accepted at start; strobe follows the move states (only report if out of range).
// Step: a column pass, a remainder run, a second column pass, then the same for rows,
//   then the move states PRDQ to PADD and the report; it reports after the first column
//   pass if no column below N holds a queen. Scans walk one entry a cycle.
// One item at a time; done pulses one cycle per item and cannot be held off.
// Synchronous reset; busy stays high while the counts clear.
module min_conflicts_queen_solver_step_unit #(
  parameter int MAX_QUEENS = mcq_pkg::MAX_QUEENS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [5:0]  column,
  input  logic [5:0]  row,
  input  logic [15:0] rand_col,
  input  logic [15:0] rand_row,
  output logic        done,
  output logic [5:0]  moved_column,
  output logic [5:0]  moved_row,
  output logic [12:0] total_conflicts,
  output logic        solved,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);
  import mcq_pkg::*;

  localparam int QW = $clog2(MAX_QUEENS);
  localparam int NW = $clog2(MAX_QUEENS + 1);
  localparam int SW = $clog2(3 * MAX_QUEENS + 1);
  localparam int TW = $clog2(MAX_QUEENS * MAX_QUEENS) + 1;

  state_t state, state_next;

  // configuration and item registers
  logic [6:0]  board_size;
  logic [QW-1:0] tcol, trow, pick;
  logic [5:0]  ocol, orow;
  logic [15:0] rc, rr;
  logic [TW-1:0] total;

  // scan bookkeeping
  logic          pass2, found;
  logic [NW-1:0] idx, ties, k;
  logic [SW-1:0] best;
  logic          v1, v2;
  logic [QW-1:0] c1, c2;
  logic          bd_placed_d;

  // memory and helper ports
  logic          clearing;
  logic [QW-1:0] bd_addr, bd_row;
  logic          bd_placed, bd_we;
  logic [QW-1:0] ln_col, ln_row;
  logic [SW-1:0] ln_sum;
  line_op_t      ln_op;
  logic          m_start, m_done;
  logic [NW-1:0] m_rem;
  logic [15:0]   m_dvd;

  logic [NW-1:0] n_lim;
  logic          accept, in_range, issue, scan_end;
  logic [SW-1:0] load;

  assign n_lim    = (32'(board_size) > MAX_QUEENS) ? NW'(MAX_QUEENS) : NW'(board_size);
  assign accept   = start && !busy;
  assign in_range = (32'(column) < MAX_QUEENS) && (32'(row) < MAX_QUEENS);
  assign busy     = clearing || (state != S_IDLE);
  assign load     = (ln_sum > SW'(LOAD_BIAS)) ? ln_sum - SW'(LOAD_BIAS) : '0;
  assign m_dvd    = (state == S_CSCAN) ? rc : rr;

  mcq_board #(.MAX_QUEENS(MAX_QUEENS)) u_board (
    .clk(clk), .rst(rst),
    .rd_col(bd_addr), .rd_row(bd_row), .rd_placed(bd_placed),
    .wr_en(bd_we), .wr_col(tcol), .wr_row(trow)
  );

  mcq_lines #(.MAX_QUEENS(MAX_QUEENS)) u_lines (
    .clk(clk), .rst(rst), .clearing(clearing),
    .rd_col(ln_col), .rd_row(ln_row), .rd_sum(ln_sum), .op(ln_op)
  );

  mcq_mod #(.MAX_QUEENS(MAX_QUEENS)) u_mod (
    .clk(clk), .rst(rst), .start(m_start),
    .dividend(m_dvd), .divisor(ties), .done(m_done), .rem(m_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd) state_next = S_CSCAN;
          else if (in_range) state_next = S_PRDQ;
          else state_next = S_REPORT;
        end
      end
      S_CSCAN: begin
        if (scan_end) begin
          if (pass2) state_next = S_RSCAN;
          else if (ties == '0) state_next = S_REPORT;
          else state_next = S_CMOD;
        end
      end
      S_CMOD:   if (m_done) state_next = S_CSCAN;
      S_RSCAN: begin
        if (scan_end) state_next = pass2 ? S_PRDQ : S_RMOD;
      end
      S_RMOD:   if (m_done) state_next = S_RSCAN;
      S_PRDQ:   state_next = S_PRDL;
      S_PRDL:   state_next = S_PRMV;
      S_PRMV:   state_next = S_PARD;
      S_PARD:   state_next = S_PADD;
      S_PADD:   state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory addressing and strobes
  always_comb begin
    issue    = ((state == S_CSCAN) || (state == S_RSCAN)) && (idx < n_lim);
    scan_end = !issue && !v1 && !v2;
    bd_addr  = (state == S_CSCAN) ? idx[QW-1:0] : tcol;
    bd_we    = (state == S_PADD);
    m_start  = 1'b0;
    ln_op    = LINE_HOLD;
    ln_col   = tcol;
    ln_row   = trow;
    unique case (state)
      S_CSCAN: begin
        ln_col  = c1;
        ln_row  = bd_row;
        m_start = scan_end && !pass2 && (ties != '0);
      end
      S_RSCAN: begin
        ln_col  = pick;
        ln_row  = idx[QW-1:0];
        m_start = scan_end && !pass2;
      end
      S_PRDL: begin
        ln_row = bd_row;
      end
      S_PRMV: begin
        ln_row = bd_row;
        if (bd_placed) ln_op = LINE_DEC;
      end
      S_PADD: begin
        ln_op = LINE_INC;
      end
      default: begin
        ln_op = LINE_HOLD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      board_size <= BOARD_SIZE_RST;
      total      <= '0;
      done       <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      pass2      <= 1'b0;
      found      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_REPORT);
      if (cfg_we) board_size <= cfg_wdata;
      // advance the scan pipeline: board read then counts in column passes
      v1 <= (state == S_CSCAN) && issue;
      v2 <= (state == S_CSCAN) ? v1 : ((state == S_RSCAN) && issue);
      if (accept) begin
        pass2 <= 1'b0;
        found <= 1'b0;
      end else if (m_done) begin
        pass2 <= 1'b1;
        found <= 1'b0;
      end else if ((state == S_CSCAN || state == S_RSCAN) && scan_end && pass2) begin
        pass2 <= 1'b0;
      end else if (v2 && pass2 && !found && k == '0) begin
        if ((state == S_CSCAN && bd_placed_d && load == best) ||
            (state == S_RSCAN && ln_sum == best)) begin
          found <= 1'b1;
        end
      end
      if (state == S_PRMV && bd_placed) begin
        total <= total - TW'(ln_sum) + TW'(LOAD_BIAS);
      end else if (state == S_PADD) begin
        total <= total + TW'(ln_sum);
      end
    end
  end

  // placed flag of the column whose counts arrive this cycle
  always_ff @(posedge clk) begin
    bd_placed_d <= bd_placed;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      tcol <= QW'(column);
      trow <= QW'(row);
      rc   <= rand_col;
      rr   <= rand_row;
      ocol <= cmd ? 6'd0 : column;
      orow <= cmd ? 6'd0 : row;
      idx  <= '0;
      ties <= '0;
      best <= '0;
    end
    if (issue) idx <= idx + NW'(1);
    c1 <= idx[QW-1:0];
    c2 <= (state == S_CSCAN) ? c1 : idx[QW-1:0];
    if (m_done) k <= m_rem;

    if (state == S_CSCAN && v2 && bd_placed_d) begin
      if (!pass2) begin
        if (ties == '0 || load > best) begin
          best <= load;
          ties <= NW'(1);
        end else if (load == best) begin
          ties <= ties + NW'(1);
        end
      end else if (!found && load == best) begin
        if (k == '0) pick <= c2;
        else k <= k - NW'(1);
      end
    end
    if (state == S_RSCAN && v2) begin
      if (!pass2) begin
        if (ties == '0 || ln_sum < best) begin
          best <= ln_sum;
          ties <= NW'(1);
        end else if (ln_sum == best) begin
          ties <= ties + NW'(1);
        end
      end else if (!found && ln_sum == best) begin
        if (k == '0) trow <= c2;
        else k <= k - NW'(1);
      end
    end
    // reset the pass bookkeeping when a scan drains
    if ((state == S_CSCAN || state == S_RSCAN) && scan_end) begin
      idx <= '0;
      if (pass2) begin
        best <= '0;
        ties <= '0;
      end
    end
    if (state == S_RSCAN && scan_end && pass2) begin
      tcol <= pick;
      ocol <= 6'(pick);
      orow <= 6'(trow);
    end
    if (state == S_REPORT) begin
      moved_column    <= ocol;
      moved_row       <= orow;
      total_conflicts <= (32'(total) > TOTAL_MAX) ? 13'(TOTAL_MAX) : 13'(total);
      solved          <= (total == '0);
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_move_report: assert property (@(posedge clk) disable iff (rst)
    (state == S_PADD) |=> (state == S_REPORT))
    else $error("queen move did not end in a report");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (busy && state == S_IDLE))
    else $error("item taken during count clear");

endmodule
